// File: hdl/rhc_pkg.sv
// Shared widths, constants and the per-cell work word of the RGB to HSV converter.
package rhc_pkg;

   localparam int CH_W      = 8;                  // one color channel
   localparam int HUE_W     = 16;                 // hue fraction bits
   localparam int DIV_W     = 11;                 // six times delta, up to 1530
   localparam int SUM_W     = DIV_W + 1;          // signed sector sum
   localparam int SAT_NUM_W = 2 * CH_W;           // 255 times delta
   localparam int STEPS     = HUE_W;              // one quotient bit per cell

   // Everything one pixel carries down the divider chain.
   typedef struct packed {
      logic [DIV_W-1:0]     hue_div;
      logic [DIV_W-1:0]     hue_rem;
      logic [HUE_W-1:0]     hue_quo;
      logic [CH_W-1:0]      sat_div;
      logic [CH_W-1:0]      sat_rem;
      logic [SAT_NUM_W-1:0] sat_num;
      logic [CH_W-1:0]      sat_quo;
      logic [CH_W-1:0]      value;
      logic                 hue_valid;
   } rhc_work_type;

endpackage

// File: hdl/rhc_channels_if.sv
// Valid/ready channel interfaces for the pixel input and the HSV result.
interface rhc_pixel_if;
   logic                    valid;
   logic                    ready;
   logic [rhc_pkg::CH_W-1:0] red;
   logic [rhc_pkg::CH_W-1:0] green;
   logic [rhc_pkg::CH_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
   logic                      valid;
   logic                      ready;
   logic [rhc_pkg::HUE_W-1:0] hue;
   logic                      hue_valid;
   logic [rhc_pkg::CH_W-1:0]  saturation;
   logic [rhc_pkg::CH_W-1:0]  value;

   modport source (output valid, output hue, output hue_valid, output saturation,
                   output value, input ready);
   modport sink   (input valid, input hue, input hue_valid, input saturation,
                   input value, output ready);
endinterface

// File: hdl/rhc_front.sv
// Front stage: max, min, delta, hue sector sum and the divider operands.
module rhc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [rhc_pkg::CH_W-1:0]  red,
   input  logic [rhc_pkg::CH_W-1:0]  green,
   input  logic [rhc_pkg::CH_W-1:0]  blue,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rhc_pkg::rhc_work_type     out_work
);
   import rhc_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   rhc_work_type         work_ff;
   rhc_work_type         work_in;

   logic [CH_W-1:0]      mx;
   logic [CH_W-1:0]      mn;
   logic [CH_W-1:0]      delta;
   logic [CH_W-1:0]      d;
   logic [DIV_W-1:0]     d6;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] sum_wrapped;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_comb begin
      mx = (red > green) ? red : green;
      if (blue > mx) begin
         mx = blue;
      end
      mn = (red < green) ? red : green;
      if (blue < mn) begin
         mn = blue;
      end
      delta = mx - mn;
      d     = (delta == '0) ? CH_W'(1) : delta;
      d6    = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};

      // Red wins ties, then green, then blue.
      if (red == mx) begin
         sum = $signed({4'b0, green}) - $signed({4'b0, blue});
      end else if (green == mx) begin
         sum = $signed({3'b0, d, 1'b0}) + $signed({4'b0, blue}) - $signed({4'b0, red});
      end else begin
         sum = $signed({2'b0, d, 2'b0}) + $signed({4'b0, red}) - $signed({4'b0, green});
      end
      sum_wrapped = sum[SUM_W-1] ? (sum + $signed({1'b0, d6})) : sum;

      work_in.hue_div   = d6;
      work_in.hue_rem   = sum_wrapped[DIV_W-1:0];
      work_in.hue_quo   = '0;
      work_in.sat_div   = mx;
      work_in.sat_rem   = '0;
      work_in.sat_num   = {delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, delta};
      work_in.sat_quo   = '0;
      work_in.value     = mx;
      work_in.hue_valid = (mx != '0);

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

endmodule

// File: hdl/rhc_cell.sv
// Divider cell: one restoring step each for hue and for saturation.
module rhc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rhc_pkg::rhc_work_type in_work,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rhc_pkg::rhc_work_type out_work
);
   import rhc_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   rhc_work_type         work_ff;
   rhc_work_type         work_in;

   logic [DIV_W:0]       hue_trial;
   logic [DIV_W:0]       hue_diff;
   logic                 hue_bit;
   logic [CH_W:0]        sat_trial;
   logic [CH_W:0]        sat_diff;
   logic                 sat_bit;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_comb begin
      // Hue is a pure fraction: shift in zeros below the remainder.
      hue_trial = {in_work.hue_rem, 1'b0};
      hue_diff  = hue_trial - {1'b0, in_work.hue_div};
      hue_bit   = (hue_trial >= {1'b0, in_work.hue_div});

      // Saturation is long division, numerator bits enter from the top down.
      sat_trial = {in_work.sat_rem, in_work.sat_num[SAT_NUM_W-1]};
      sat_diff  = sat_trial - {1'b0, in_work.sat_div};
      sat_bit   = (sat_trial >= {1'b0, in_work.sat_div});

      work_in         = in_work;
      work_in.hue_rem = hue_bit ? hue_diff[DIV_W-1:0] : hue_trial[DIV_W-1:0];
      work_in.hue_quo = {in_work.hue_quo[HUE_W-2:0], hue_bit};
      work_in.sat_rem = sat_bit ? sat_diff[CH_W-1:0] : sat_trial[CH_W-1:0];
      work_in.sat_num = {in_work.sat_num[SAT_NUM_W-2:0], 1'b0};
      work_in.sat_quo = {in_work.sat_quo[CH_W-2:0], sat_bit};

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

endmodule

// File: hdl/rgb_to_hsv_converter_unit.sv
// Pipeline: front stage plus 16 cells between an accepted pixel word and its HSV word.
// Throughput: one pixel word per cycle while the receiver is ready; every stage has its own
// valid bit and takes a new word whenever it is empty or its successor takes its current one.
// The divider chain has 16 cells, one hue and one saturation bit per cell.
// Reset (synchronous, active high) clears all valid bits; no data is held across it.
module rgb_to_hsv_converter_unit (
   input  logic           clock,
   input  logic           reset,
   rhc_pixel_if.sink      req_pixel,
   rhc_hsv_if.source      rsp_hsv
);
   import rhc_pkg::*;

   logic                 valid_chain [STEPS+1];
   logic                 ready_chain [STEPS+1];
   rhc_work_type         work_chain  [STEPS+1];

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_pixel.valid),
      .in_ready  (req_pixel.ready),
      .red       (req_pixel.red),
      .green     (req_pixel.green),
      .blue      (req_pixel.blue),
      .out_valid (valid_chain[0]),
      .out_ready (ready_chain[0]),
      .out_work  (work_chain[0])
   );

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      rhc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_work   (work_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_ready (ready_chain[i+1]),
         .out_work  (work_chain[i+1])
      );
   end

   assign ready_chain[STEPS] = rsp_hsv.ready;
   assign rsp_hsv.valid      = valid_chain[STEPS];
   assign rsp_hsv.hue        = work_chain[STEPS].hue_quo;
   assign rsp_hsv.hue_valid  = work_chain[STEPS].hue_valid;
   // A black pixel divides by zero in the saturation lane, so its quotient is dropped.
   assign rsp_hsv.saturation = work_chain[STEPS].hue_valid ? work_chain[STEPS].sat_quo : '0;
   assign rsp_hsv.value      = work_chain[STEPS].value;

endmodule

// File: sim/rgb_to_hsv_converter_unit_tb.sv
// Self-checking testbench for the RGB to HSV converter: random pixel stream with handshake gaps.
module rgb_to_hsv_converter_unit_tb;
   import rhc_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic             hue_valid;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  value;
   } hsv_word_type;

   localparam int HOLDOFF_CYCLES = 200;
   localparam int DRAIN_CYCLES   = 40;

   logic clock;
   logic reset;

   rhc_pixel_if pixel_if ();
   rhc_hsv_if   hsv_if ();

   rgb_to_hsv_converter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_pixel (pixel_if),
      .rsp_hsv   (hsv_if)
   );

   rgb_pixel_type pending_pixels[$];
   hsv_word_type  expected_hsv[$];
   int            mismatch_count;
   int            send_idle_pct;
   int            recv_stall_pct;
   logic          holdoff_go;
   logic          holdoff_seen;
   int            holdoff_left;
   rgb_pixel_type next_pixel;
   hsv_word_type  want;
   hsv_word_type  got;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Expected HSV word for one pixel.
   function automatic hsv_word_type hsv_of_pixel(rgb_pixel_type px);
      int           r;
      int           g;
      int           b;
      int           mx;
      int           mn;
      int           delta;
      int           d;
      int           sum;
      longint       frac;
      hsv_word_type w;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      delta = mx - mn;
      w = '0;
      w.value = mx[CH_W-1:0];
      if (mx != 0) begin
         d = (delta == 0) ? 1 : delta;
         w.hue_valid = 1'b1;
         sum = (255 * delta) / mx;
         w.saturation = sum[CH_W-1:0];
         if (r == mx) sum = g - b;
         else if (g == mx) sum = 2 * d + b - r;
         else sum = 4 * d + r - g;
         if (sum < 0) sum = sum + 6 * d;
         frac = (longint'(sum) * 65536) / (6 * d);
         w.hue = frac[HUE_W-1:0];
      end
      return w;
   endfunction

   function automatic rgb_pixel_type random_pixel();
      rgb_pixel_type px;
      logic [CH_W-1:0] hi;
      logic [CH_W-1:0] lo;
      int kind;
      kind = $urandom_range(9);
      px = rgb_pixel_type'($urandom);
      hi = $urandom_range(255);
      lo = $urandom_range(hi);
      case (kind)
         4: begin
            px = '{hi, hi, hi};
         end
         5: begin
            case ($urandom_range(2))
               0: px.red = '0;
               1: px.green = '0;
               default: px.blue = '0;
            endcase
         end
         // Two channels tie for the largest, to exercise the sector priority.
         6: begin
            case ($urandom_range(2))
               0: px = '{hi, hi, lo};
               1: px = '{lo, hi, hi};
               default: px = '{hi, lo, hi};
            endcase
         end
         7: begin
            px.red = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            px.green = ($urandom_range(1) != 0) ? 8'hFE : 8'h01;
            px.blue = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         end
         8: begin
            px = '0;
         end
         9: begin
            px = '0;
            case ($urandom_range(2))
               0: px.red = hi;
               1: px.green = hi;
               default: px.blue = hi;
            endcase
         end
         default: begin
         end
      endcase
      return px;
   endfunction

   // Pixel driver: a word is accepted when valid and ready were both high at this edge.
   always @(posedge clock) begin
      if (reset) begin
         pixel_if.valid <= 1'b0;
      end else begin
         if (pixel_if.valid && pixel_if.ready) begin
            expected_hsv.push_back(
               hsv_of_pixel('{pixel_if.red, pixel_if.green, pixel_if.blue}));
         end
         if (!pixel_if.valid || pixel_if.ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_pixel = pending_pixels.pop_front();
               pixel_if.valid <= 1'b1;
               pixel_if.red <= next_pixel.red;
               pixel_if.green <= next_pixel.green;
               pixel_if.blue <= next_pixel.blue;
            end else begin
               pixel_if.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started once on request.
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
         holdoff_seen <= 1'b0;
      end else if (holdoff_go && !holdoff_seen) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_seen <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Result monitor and receiver ready.
   always @(posedge clock) begin
      if (reset) begin
         hsv_if.ready <= 1'b0;
      end else begin
         if (hsv_if.valid && hsv_if.ready) begin
            got = '{hsv_if.hue, hsv_if.hue_valid, hsv_if.saturation, hsv_if.value};
            if (expected_hsv.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("ERROR: unexpected HSV word hue=%0d hv=%0d sat=%0d val=%0d",
                           got.hue, got.hue_valid, got.saturation, got.value);
            end else begin
               want = expected_hsv.pop_front();
               if (got.hue != want.hue || got.hue_valid != want.hue_valid ||
                   got.saturation != want.saturation || got.value != want.value) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("ERROR: exp h=%0d hv=%0d s=%0d v=%0d got h=%0d hv=%0d s=%0d v=%0d",
                              want.hue, want.hue_valid, want.saturation, want.value,
                              got.hue, got.hue_valid, got.saturation, got.value);
               end
            end
         end
         hsv_if.ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      rgb_pixel_type directed[$];
      int phase;
      reset = 1'b1;
      pixel_if.valid = 1'b0;
      pixel_if.red = '0;
      pixel_if.green = '0;
      pixel_if.blue = '0;
      hsv_if.ready = 1'b0;
      mismatch_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      holdoff_go = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Black, greys, primaries, secondaries, ties and the wrap of a negative sum.
      directed = '{
         '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd1, 8'd1, 8'd1},
         '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255},
         '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255},
         '{8'd255, 8'd0, 8'd1}, '{8'd255, 8'd1, 8'd0}, '{8'd1, 8'd0, 8'd0},
         '{8'd0, 8'd1, 8'd0}, '{8'd0, 8'd0, 8'd1}, '{8'd255, 8'd128, 8'd0},
         '{8'd128, 8'd255, 8'd0}, '{8'd200, 8'd200, 8'd100}, '{8'd100, 8'd200, 8'd200},
         '{8'd200, 8'd100, 8'd200}, '{8'd255, 8'd254, 8'd0}, '{8'd0, 8'd1, 8'd255},
         '{8'd254, 8'd0, 8'd255}, '{8'd170, 8'd85, 8'd254}
      };
      foreach (directed[i]) pending_pixels.push_back(directed[i]);

      for (phase = 0; phase < 4; phase++) begin
         while (pending_pixels.size() != 0) @(negedge clock);
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 73; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 73; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         repeat (140) pending_pixels.push_back(random_pixel());
      end

      // Sender keeps offering while the receiver holds off, so the pipeline backs up.
      while (pending_pixels.size() != 0) @(negedge clock);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      holdoff_go = 1'b1;
      repeat (60) pending_pixels.push_back(random_pixel());

      while (pending_pixels.size() != 0 || pixel_if.valid || expected_hsv.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
